[sv/call_return_shadow_stack_assert.svh]
// Assertion macros for the call/return shadow stack.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef CALL_RETURN_SHADOW_STACK_ASSERT_SVH
`define CALL_RETURN_SHADOW_STACK_ASSERT_SVH

// same-cycle implication
`define CRSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CRSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/crss_pkg.sv]
// Shared types, sizes and codes of the call/return shadow stack.
// No dependencies; used by the interfaces, the cell, the top level and the checker.
package crss_pkg;

	localparam int SYMBOLS     = 256;
	localparam int STACK_DEPTH = 64;

	localparam int SYM_AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
	localparam int SYM_CW = $clog2(SYMBOLS + 1);
	localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int STK_CW = $clog2(STACK_DEPTH + 1);

	// field widths
	localparam int SYM_IDX_W = 8;
	localparam int ADDR_W    = 32;
	localparam int EV_W      = 3;
	localparam int LEVEL_W   = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 9;

	// instruction decode
	localparam logic [31:0] RET_MASK   = 32'h000f_f07f;
	localparam logic [31:0] RET_MATCH  = 32'h0000_8067;
	localparam logic [31:0] OPC_MASK   = 32'h0000_007f;
	localparam logic [31:0] JAL_OPC    = 32'h0000_006f;
	localparam logic [31:0] JALR_MASK  = 32'h0000_707f;
	localparam logic [31:0] JALR_MATCH = 32'h0000_0067;

	localparam logic [CFG_IDX_W-1:0] CFG_TRACE_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 2'd1;

	localparam logic OP_LOAD = 1'b0;

	typedef enum logic [EV_W-1:0] {
		EV_NONE      = 3'd0,
		EV_CALL      = 3'd1,
		EV_RET       = 3'd2,
		EV_UNMATCHED = 3'd3,
		EV_OVERFLOW  = 3'd4
	} ev_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALL,
		ST_RET,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                 operation;
		logic [SYM_IDX_W-1:0] sym_index;
		logic [ADDR_W-1:0]    sym_addr;
		logic [31:0]          inst;
		logic [ADDR_W-1:0]    pc;
		logic [ADDR_W-1:0]    target_pc;
	} in_item_t;

	typedef struct packed {
		logic [EV_W-1:0]      event_res;
		logic [LEVEL_W-1:0]   level;
		logic [SYM_IDX_W-1:0] symbol;
		logic [ADDR_W-1:0]    report_addr;
	} out_item_t;

	// per-cell control
	typedef struct packed {
		logic              rotate;
		logic              wr_en;
		logic [SYM_AW-1:0] wr_sym;
	} cell_ctl_t;

endpackage

[sv/crss_in_if.sv]
// Input channel of the shadow stack: valid/ready plus one item.
// Depends on crss_pkg.
interface crss_in_if;
	logic                valid;
	logic                ready;
	crss_pkg::in_item_t  item;
	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

[sv/crss_out_if.sv]
// Result channel of the shadow stack: valid/ready plus one result.
// Depends on crss_pkg.
interface crss_out_if;
	logic                valid;
	logic                ready;
	crss_pkg::out_item_t item;
	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

[sv/crss_cfg_if.sv]
// Register write channel: valid/ready, register index and data.
// Depends on crss_pkg.
interface crss_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [crss_pkg::CFG_IDX_W-1:0]     idx;
	logic [crss_pkg::CFG_DAT_W-1:0]     data;
	modport source (output valid, output idx, output data, input ready);
	modport sink   (input valid, input idx, input data, output ready);
endinterface

[sv/crss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[sv/crss_cell.sv]
// One shadow stack cell: holds a symbol index, takes a push or its neighbor's value.
// Depends on crss_pkg.
module crss_cell (
	input  logic                          clk,
	input  crss_pkg::cell_ctl_t           ctl,
	input  logic [crss_pkg::SYM_AW-1:0]   nbr_sym,
	output logic [crss_pkg::SYM_AW-1:0]   sym
);
	logic [crss_pkg::SYM_AW-1:0] sym_q;

	// push has priority; rotate passes the ring one place toward cell 0
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			sym_q <= ctl.wr_sym;
		end else if (ctl.rotate) begin
			sym_q <= nbr_sym;
		end
	end

	assign sym = sym_q;
endmodule

[sv/call_return_shadow_stack.sv]
// Shadow stack of function calls driven by retired RISC-V instructions. One result beat
// per input beat. Load beats, beats with tracing off, beats that are no call/return and
// calls with no active symbols go straight to the result. A call (jal/jalr) scans the
// symbol table RAM one entry per cycle from index 0 and stops at the first match or at the
// last active entry. A return rotates the ring of STACK_DEPTH stack cells once past cell 0,
// reading each entry's address from the table RAM. Both scans use its single read port.
// One beat is worked on at a time; a finished result waits in the output register.
// Depends on crss_pkg, crss_in_if, crss_out_if, crss_cfg_if, crss_ram, crss_cell.
module call_return_shadow_stack (
	input  logic           clk,
	input  logic           arst_n,
	crss_in_if.sink        in_ch,
	crss_out_if.source     out_ch,
	crss_cfg_if.sink       cfg_ch
);
	localparam int SYM_AW = crss_pkg::SYM_AW;
	localparam int SYM_CW = crss_pkg::SYM_CW;
	localparam int STK_AW = crss_pkg::STK_AW;
	localparam int STK_CW = crss_pkg::STK_CW;
	localparam int DEPTH  = crss_pkg::STACK_DEPTH;

	crss_pkg::state_t    state_q, state_n;
	logic                trace_en_q;
	logic [crss_pkg::CFG_DAT_W-1:0] sym_cnt_q;
	logic [STK_CW-1:0]   fill_q;
	logic [SYM_CW-1:0]   sidx_q;
	logic [STK_CW-1:0]   rot_q;
	logic                rd_vld_s1;
	logic [SYM_CW-1:0]   ctag_s1;
	logic [STK_CW-1:0]   rtag_s1;
	logic [SYM_AW-1:0]   rsym_s1;
	logic                hit_q;
	logic [31:0]         best_q;
	logic [STK_AW-1:0]   found_q;
	logic [SYM_AW-1:0]   fsym_q;
	logic [31:0]         tgt_q, pc_q;
	crss_pkg::out_item_t pend_q, out_q;
	logic                out_valid_q;

	logic                in_fire, out_load;
	logic                is_ret, is_jmp, imm_none;
	logic [SYM_CW-1:0]   sym_lim;
	logic                iss;
	logic [SYM_AW-1:0]   ram_raddr;
	logic [31:0]         ram_rdata;
	logic                ram_we;
	logic                call_match, call_last, call_done, stk_full, push;
	logic                r_take, ret_done, hit_n;
	logic [STK_AW-1:0]   found_n;
	logic [SYM_AW-1:0]   fsym_n;
	logic [31:0]         best_n;
	logic [SYM_AW-1:0]   cell_sym [DEPTH];

	// decode of the offered beat
	always_comb begin
		is_ret  = (in_ch.item.inst & crss_pkg::RET_MASK) == crss_pkg::RET_MATCH;
		is_jmp  = ((in_ch.item.inst & crss_pkg::OPC_MASK) == crss_pkg::JAL_OPC) ||
		          ((in_ch.item.inst & crss_pkg::JALR_MASK) == crss_pkg::JALR_MATCH);
		sym_lim = (int'(sym_cnt_q) > crss_pkg::SYMBOLS) ?
		          SYM_CW'(crss_pkg::SYMBOLS) : SYM_CW'(sym_cnt_q);
		imm_none = (in_ch.item.operation == crss_pkg::OP_LOAD) || !trace_en_q ||
		           (!is_ret && !is_jmp) || (!is_ret && sym_lim == '0);
	end

	assign in_ch.ready = (state_q == crss_pkg::ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign cfg_ch.ready = 1'b1;

	// symbol table
	assign ram_we = in_fire && (in_ch.item.operation == crss_pkg::OP_LOAD) &&
	                (int'(in_ch.item.sym_index) < crss_pkg::SYMBOLS);

	crss_ram #(.WIDTH(32), .DEPTH(crss_pkg::SYMBOLS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (SYM_AW'(in_ch.item.sym_index)),
		.wdata (in_ch.item.sym_addr),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// read issue: table walk for calls, ring head for returns
	always_comb begin
		iss       = 1'b0;
		ram_raddr = sidx_q[SYM_AW-1:0];
		case (state_q)
			crss_pkg::ST_CALL: begin
				iss = sidx_q < sym_lim;
			end
			crss_pkg::ST_RET: begin
				iss       = int'(rot_q) < DEPTH;
				ram_raddr = cell_sym[0];
			end
			default: begin
				iss = 1'b0;
			end
		endcase
	end

	// call evaluation
	always_comb begin
		call_match = rd_vld_s1 && (ram_rdata == tgt_q);
		call_last  = rd_vld_s1 && (ctag_s1 == sym_lim - SYM_CW'(1));
		call_done  = (state_q == crss_pkg::ST_CALL) && (call_match || call_last);
		stk_full   = int'(fill_q) >= DEPTH;
		push       = call_done && call_match && !stk_full;
	end

	// return evaluation: ascending scan, ties go to the higher entry
	always_comb begin
		r_take = (state_q == crss_pkg::ST_RET) && rd_vld_s1 && (rtag_s1 < fill_q) &&
		         (tgt_q > ram_rdata) &&
		         ((ram_rdata > best_q) || (hit_q && ram_rdata == best_q));
		hit_n   = hit_q || r_take;
		best_n  = r_take ? ram_rdata : best_q;
		found_n = r_take ? rtag_s1[STK_AW-1:0] : found_q;
		fsym_n  = r_take ? rsym_s1 : fsym_q;
		ret_done = (state_q == crss_pkg::ST_RET) && rd_vld_s1 &&
		           (rtag_s1 == STK_CW'(DEPTH - 1));
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			crss_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (imm_none) begin
						state_n = crss_pkg::ST_DONE;
					end else if (is_ret) begin
						state_n = crss_pkg::ST_RET;
					end else begin
						state_n = crss_pkg::ST_CALL;
					end
				end
			end
			crss_pkg::ST_CALL: begin
				if (call_done) state_n = crss_pkg::ST_DONE;
			end
			crss_pkg::ST_RET: begin
				if (ret_done) state_n = crss_pkg::ST_DONE;
			end
			crss_pkg::ST_DONE: begin
				if (!out_valid_q || out_ch.ready) state_n = crss_pkg::ST_IDLE;
			end
			default: begin
				state_n = crss_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs of the state machine
	always_comb begin
		out_load = (state_q == crss_pkg::ST_DONE) && (!out_valid_q || out_ch.ready);
	end

	// ring of stack cells
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		crss_pkg::cell_ctl_t ctl;
		always_comb begin
			ctl.rotate = (state_q == crss_pkg::ST_RET) && (int'(rot_q) < DEPTH);
			ctl.wr_en  = push && (fill_q == STK_CW'(k));
			ctl.wr_sym = ctag_s1[SYM_AW-1:0];
		end
		crss_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.nbr_sym (cell_sym[(k + 1) % DEPTH]),
			.sym     (cell_sym[k])
		);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= crss_pkg::ST_IDLE;
			trace_en_q  <= 1'b0;
			sym_cnt_q   <= '0;
			fill_q      <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_n;
			rd_vld_s1 <= iss;
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.idx)
					crss_pkg::CFG_TRACE_ENABLE: trace_en_q <= cfg_ch.data[0];
					crss_pkg::CFG_SYMBOL_COUNT: sym_cnt_q  <= cfg_ch.data;
					default: begin
					end
				endcase
			end
			if (in_fire) begin
				hit_q <= 1'b0;
			end else if (state_q == crss_pkg::ST_RET) begin
				hit_q <= hit_n;
			end
			if (push) begin
				fill_q <= fill_q + STK_CW'(1);
			end else if (ret_done && hit_n) begin
				fill_q <= STK_CW'(found_n) + STK_CW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		ctag_s1 <= sidx_q;
		rtag_s1 <= rot_q;
		rsym_s1 <= cell_sym[0];
		if (in_fire) begin
			tgt_q  <= in_ch.item.target_pc;
			pc_q   <= in_ch.item.pc;
			sidx_q <= '0;
			rot_q  <= '0;
			best_q <= '0;
			pend_q <= '0;
		end else begin
			if (iss && state_q == crss_pkg::ST_CALL) sidx_q <= sidx_q + SYM_CW'(1);
			if (iss && state_q == crss_pkg::ST_RET)  rot_q  <= rot_q + STK_CW'(1);
		end
		if (state_q == crss_pkg::ST_RET) begin
			best_q  <= best_n;
			found_q <= found_n;
			fsym_q  <= fsym_n;
		end
		// result of a finished scan
		if (call_done) begin
			if (!call_match) begin
				pend_q <= '0;
			end else if (stk_full) begin
				pend_q.event_res   <= crss_pkg::EV_OVERFLOW;
				pend_q.level       <= '0;
				pend_q.symbol      <= crss_pkg::SYM_IDX_W'(ctag_s1);
				pend_q.report_addr <= tgt_q;
			end else begin
				pend_q.event_res   <= crss_pkg::EV_CALL;
				pend_q.level       <= crss_pkg::LEVEL_W'(fill_q);
				pend_q.symbol      <= crss_pkg::SYM_IDX_W'(ctag_s1);
				pend_q.report_addr <= ram_rdata;
			end
		end else if (ret_done) begin
			pend_q.report_addr <= pc_q;
			if (hit_n) begin
				pend_q.event_res <= crss_pkg::EV_RET;
				pend_q.level     <= crss_pkg::LEVEL_W'(found_n);
				pend_q.symbol    <= crss_pkg::SYM_IDX_W'(fsym_n);
			end else begin
				pend_q.event_res <= crss_pkg::EV_UNMATCHED;
				pend_q.level     <= '0;
				pend_q.symbol    <= '0;
			end
		end
		if (out_load) out_q <= pend_q;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.item  = out_q;
endmodule

[sv/crss_checker.sv]
// Port-level checks of the shadow stack, bound to the top level.
// Depends on crss_pkg and call_return_shadow_stack_assert.svh.
`include "call_return_shadow_stack_assert.svh"

module crss_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input crss_pkg::out_item_t out_item
);
	// a held result beat stays offered
	`CRSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
	// a held result beat keeps its payload
	`CRSS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_item), "result changed")
	// one beat at a time: ready drops after an accept
	`CRSS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second beat taken")
	// event code is in range
	`CRSS_ASSERT_NOW(a_ev_range, out_valid, out_item.event_res <= crss_pkg::EV_OVERFLOW, "bad event")
	// no-event results carry zero fields
	`CRSS_ASSERT_NOW(a_none_zero, out_valid && out_item.event_res == crss_pkg::EV_NONE, out_item.level == '0 && out_item.symbol == '0 && out_item.report_addr == '0, "none not zero")
endmodule

bind call_return_shadow_stack crss_checker u_crss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_item  (out_ch.item)
);
